// ===== design/esp_pkg.sv =====
`timescale 1ns / 1ps

package esp_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int ERR_WIDTH   = COORD_WIDTH + 2;
    localparam int CNT_WIDTH   = COORD_WIDTH + 2;
    localparam int PADDR_WIDTH = 4;
    localparam int PDATA_WIDTH = 32;

    // runaway guard on the number of error steps per query
    localparam logic [CNT_WIDTH-1:0] STEP_LIMIT = CNT_WIDTH'((2 << COORD_WIDTH) + 4);

    typedef logic [COORD_WIDTH-1:0] coord_t;

    localparam logic FUNC_RESTART = 1'b0;
    localparam logic FUNC_QUERY   = 1'b1;

    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_END_X   = 2'd2;
    localparam logic [1:0] REG_END_Y   = 2'd3;

    typedef enum logic [1:0] {
        PH_INIT  = 2'd0,
        PH_FIRST = 2'd1,
        PH_MID   = 2'd2,
        PH_LAST  = 2'd3
    } edge_phase_t;

    localparam logic [1:0] SPAN_FIRST = 2'd0;
    localparam logic [1:0] SPAN_MID   = 2'd1;
    localparam logic [1:0] SPAN_LAST  = 2'd2;

    typedef struct packed {
        logic restart;
        logic start_q;
        logic step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic done;
    } status_t;

endpackage

// ===== design/esp_ifs.sv =====
`timescale 1ns / 1ps

interface esp_item_if
    import esp_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   func;
    coord_t scan_row;

    modport source (output valid, output func, output scan_row, input ready);
    modport sink   (input valid, input func, input scan_row, output ready);
endinterface

interface esp_span_if
    import esp_pkg::*;
;
    logic       valid;
    logic       ready;
    coord_t     span_row;
    coord_t     span_left;
    coord_t     span_right;
    logic [1:0] phase;

    modport source (output valid, output span_row, output span_left, output span_right,
                    output phase, input ready);
    modport sink   (input valid, input span_row, input span_left, input span_right,
                    input phase, output ready);
endinterface

// ===== design/bresenham_edge_span_stepper.sv =====
`timescale 1ns / 1ps

// Bresenham edge span stepper.
// Program the edge endpoints over the APB port (start_x, start_y, end_x,
// end_y at byte offsets 0, 4, 8, 12), then send a restart transaction
// (func 0) on the item channel to load the stepper from them. Each query
// transaction (func 1, scan_row) yields at most one span transaction on the
// span channel: the row the stepper stands on, its leftmost and rightmost x
// and a phase (0 first, 1 middle, 2 end point reached). A row above the
// current y or below the end y yields nothing.
// A restart or an out-of-range query takes no error steps. An in-range
// query is accepted, then takes its error steps (the pixels the edge covers
// on that row plus the step onto the next row; up to dx+1 on shallow edges,
// one or two on steep ones), then loads the result register once it is free.
// There is a single error-step unit; no item is taken before the load.
// Reset clears the endpoint registers and leaves the stepper as after a
// restart at the origin. When the receiver stalls, the finished span waits
// in the output register; the next transaction is still accepted, and a
// second result is held in the datapath until the register drains.
module bresenham_edge_span_stepper
    import esp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    esp_item_if.sink               item,
    esp_span_if.source             span,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [PDATA_WIDTH-1:0] pwdata,
    output logic [PDATA_WIDTH-1:0] prdata,
    output logic                   pready
);

    coord_t     start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    cmd_t       cmd;
    status_t    stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_WIDTH-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_START_X: start_x_reg <= pwdata[COORD_WIDTH-1:0];
                REG_START_Y: start_y_reg <= pwdata[COORD_WIDTH-1:0];
                REG_END_X:   end_x_reg   <= pwdata[COORD_WIDTH-1:0];
                REG_END_Y:   end_y_reg   <= pwdata[COORD_WIDTH-1:0];
                default:     start_x_reg <= start_x_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_START_X: prdata = PDATA_WIDTH'(start_x_reg);
            REG_START_Y: prdata = PDATA_WIDTH'(start_y_reg);
            REG_END_X:   prdata = PDATA_WIDTH'(end_x_reg);
            REG_END_Y:   prdata = PDATA_WIDTH'(end_y_reg);
            default:     prdata = '0;
        endcase
    end

    esp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_func   (item.func),
        .in_ready  (item.ready),
        .stat      (stat),
        .out_ready (span.ready),
        .out_valid (span.valid),
        .cmd       (cmd)
    );

    esp_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .start_x    (start_x_reg),
        .start_y    (start_y_reg),
        .end_x      (end_x_reg),
        .end_y      (end_y_reg),
        .scan_row   (item.scan_row),
        .span_row   (span.span_row),
        .span_left  (span.span_left),
        .span_right (span.span_right),
        .span_phase (span.phase)
    );

endmodule

// ===== design/esp_ctrl.sv =====
`timescale 1ns / 1ps

module esp_ctrl
    import esp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_func,
    output logic    in_ready,
    input  status_t stat,
    input  logic    out_ready,
    output logic    out_valid,
    output cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_func == FUNC_RESTART)
                    begin
                        cmd.restart = 1'b1;
                    end
                    else if (stat.in_range)
                    begin
                        cmd.start_q = 1'b1;
                        state_next  = S_STEP;
                    end
                end
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // wait until the output register is empty or drains this cycle
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/esp_dpath.sv =====
`timescale 1ns / 1ps

module esp_dpath
    import esp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    stat,
    input  coord_t     start_x,
    input  coord_t     start_y,
    input  coord_t     end_x,
    input  coord_t     end_y,
    input  coord_t     scan_row,
    output coord_t     span_row,
    output coord_t     span_left,
    output coord_t     span_right,
    output logic [1:0] span_phase
);

    coord_t                      cur_x_reg, cur_x_next;
    coord_t                      cur_y_reg, cur_y_next;
    coord_t                      goal_x_reg, goal_x_next;
    coord_t                      goal_y_reg, goal_y_next;
    coord_t                      delta_x_reg, delta_x_next;
    coord_t                      delta_y_reg, delta_y_next;
    logic signed [ERR_WIDTH-1:0] err_reg, err_next;
    logic                        step_x_neg_reg, step_x_neg_next;
    logic                        step_y_neg_reg, step_y_neg_next;
    edge_phase_t                 phase_reg, phase_next;
    logic [CNT_WIDTH-1:0]        cnt_reg, cnt_next;
    coord_t                      row_reg, row_next;
    coord_t                      first_x_reg, first_x_next;
    coord_t                      last_x_reg, last_x_next;

    coord_t                      out_row_reg, out_left_reg, out_right_reg;
    logic [1:0]                  out_phase_reg;

    // restart setup
    logic                        sx_lt, sy_lt;
    coord_t                      rs_dx, rs_dy;
    logic signed [ERR_WIDTH-1:0] rs_err;

    // one error step
    logic signed [ERR_WIDTH-1:0] dx_s, dy_s, err_a, err_b;
    logic                        at_end, y_go, x_go;
    coord_t                      x_new, y_new;
    logic [CNT_WIDTH-1:0]        cnt_inc;
    logic                        done;
    logic [1:0]                  phase_code;

    assign sx_lt  = start_x < end_x;
    assign sy_lt  = start_y < end_y;
    assign rs_dx  = sx_lt ? (end_x - start_x) : (start_x - end_x);
    assign rs_dy  = sy_lt ? (end_y - start_y) : (start_y - end_y);
    assign rs_err = (rs_dx > rs_dy) ? $signed(ERR_WIDTH'(rs_dx >> 1))
                                    : -$signed(ERR_WIDTH'(rs_dy >> 1));

    assign dx_s   = $signed(ERR_WIDTH'(delta_x_reg));
    assign dy_s   = $signed(ERR_WIDTH'(delta_y_reg));
    assign at_end = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);
    assign y_go   = err_reg < dy_s;
    assign x_go   = err_reg > -dx_s;
    assign err_a  = y_go ? (err_reg + dx_s) : err_reg;
    assign err_b  = x_go ? (err_a - dy_s) : err_a;
    assign y_new  = !y_go ? cur_y_reg :
                    (step_y_neg_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1));
    assign x_new  = !x_go ? cur_x_reg :
                    (step_x_neg_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1));
    assign cnt_inc = cnt_reg + 1'b1;
    assign done    = at_end || (y_new != row_reg) || (cnt_inc == STEP_LIMIT);

    assign stat.in_range = (scan_row >= cur_y_reg) && (scan_row <= goal_y_reg);
    assign stat.done     = done;

    always_comb
    begin
        unique case (phase_reg)
            PH_LAST:  phase_code = SPAN_LAST;
            PH_FIRST: phase_code = SPAN_FIRST;
            default:  phase_code = SPAN_MID;
        endcase
    end

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        delta_x_next    = delta_x_reg;
        delta_y_next    = delta_y_reg;
        err_next        = err_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        row_next        = row_reg;
        first_x_next    = first_x_reg;
        last_x_next     = last_x_reg;

        if (cmd.restart)
        begin
            goal_x_next     = end_x;
            goal_y_next     = end_y;
            cur_x_next      = start_x;
            cur_y_next      = start_y;
            delta_x_next    = rs_dx;
            delta_y_next    = rs_dy;
            step_x_neg_next = !sx_lt;
            step_y_neg_next = !sy_lt;
            err_next        = rs_err;
            phase_next      = PH_INIT;
        end

        if (cmd.start_q)
        begin
            row_next     = cur_y_reg;
            first_x_next = cur_x_reg;
            last_x_next  = cur_x_reg;
            cnt_next     = '0;
        end

        if (cmd.step)
        begin
            if (!at_end)
            begin
                err_next   = err_b;
                cur_x_next = x_new;
                cur_y_next = y_new;
                cnt_next   = cnt_inc;
                if (x_go && (y_new == row_reg))
                begin
                    last_x_next = x_new;
                end
            end
            if (done)
            begin
                if (at_end)
                begin
                    phase_next = PH_LAST;
                end
                else if (phase_reg == PH_INIT)
                begin
                    phase_next = PH_FIRST;
                end
                else
                begin
                    phase_next = PH_MID;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            goal_x_reg     <= '0;
            goal_y_reg     <= '0;
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            err_reg        <= '0;
            step_x_neg_reg <= 1'b1;
            step_y_neg_reg <= 1'b1;
            phase_reg      <= PH_INIT;
            cnt_reg        <= '0;
            row_reg        <= '0;
            first_x_reg    <= '0;
            last_x_reg     <= '0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            goal_x_reg     <= goal_x_next;
            goal_y_reg     <= goal_y_next;
            delta_x_reg    <= delta_x_next;
            delta_y_reg    <= delta_y_next;
            err_reg        <= err_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            row_reg        <= row_next;
            first_x_reg    <= first_x_next;
            last_x_reg     <= last_x_next;
        end
    end

    // result register, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_row_reg   <= row_reg;
            out_left_reg  <= (first_x_reg < last_x_reg) ? first_x_reg : last_x_reg;
            out_right_reg <= (first_x_reg < last_x_reg) ? last_x_reg : first_x_reg;
            out_phase_reg <= phase_code;
        end
    end

    assign span_row   = out_row_reg;
    assign span_left  = out_left_reg;
    assign span_right = out_right_reg;
    assign span_phase = out_phase_reg;

endmodule
